// File: rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg: shared types, codes and helpers for the thruster mixer
// Command codes, register indexes, the decoded command that travels from the
// front end to the back end, the configuration bundle and the slew function.
// ----------------------------------------------------------------------------
package tms_pkg;

  // Input opcodes
  localparam logic [3:0] OP_SET_ALL   = 4'd0;
  localparam logic [3:0] OP_PORT      = 4'd1;
  localparam logic [3:0] OP_VERTICAL  = 4'd2;
  localparam logic [3:0] OP_STARBOARD = 4'd3;
  localparam logic [3:0] OP_THROTTLE  = 4'd4;
  localparam logic [3:0] OP_YAW       = 4'd5;
  localparam logic [3:0] OP_LIFT      = 4'd6;
  localparam logic [3:0] OP_STOP      = 4'd7;
  localparam logic [3:0] OP_TICK      = 4'd8;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE_HIGH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIDPOINT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_SPAN  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_SPAN  = 3'd5;

  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned PULSE_W     = 12;
  localparam int unsigned SPAN_W      = 10;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 48;

  // Command queue depth
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Reset values
  localparam logic [SPAN_W-1:0]  STEP_SIZE_RST     = 10'd40;
  localparam logic [PULSE_W-1:0] DEADZONE_LOW_RST  = 12'd1450;
  localparam logic [PULSE_W-1:0] DEADZONE_HIGH_RST = 12'd1550;
  localparam logic [PULSE_W-1:0] MIDPOINT_RST      = 12'd1500;
  localparam logic [SPAN_W-1:0]  SPAN_RST          = 10'd500;
  localparam logic [PULSE_W-1:0] NEUTRAL_PULSE     = 12'd1500;

  // Kind of work the back end carries out
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_SET,
    CMD_STOP,
    CMD_TICK
  } cmd_kind_t;

  // Axis masks for target writes
  localparam logic [2:0] AXIS_PORT      = 3'b001;
  localparam logic [2:0] AXIS_VERTICAL  = 3'b010;
  localparam logic [2:0] AXIS_STARBOARD = 3'b100;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         mask;
    logic [PULSE_W-1:0] port;
    logic [PULSE_W-1:0] vertical;
    logic [PULSE_W-1:0] starboard;
    logic               arm;
  } cmd_t;

  typedef struct packed {
    logic [SPAN_W-1:0]  step_size;
    logic [PULSE_W-1:0] deadzone_low;
    logic [PULSE_W-1:0] deadzone_high;
    logic [PULSE_W-1:0] midpoint;
    logic [SPAN_W-1:0]  forward_span;
    logic [SPAN_W-1:0]  reverse_span;
  } cfg_t;

  // One slew step of a driven pulse toward its target
  function automatic logic [PULSE_W-1:0] approach(
    input logic [PULSE_W-1:0] tgt,
    input logic [PULSE_W-1:0] cur,
    input cfg_t               cfg
  );
    logic signed [13:0] t, c, m, diff, mag, res, dmt, dmc, step;
    t    = $signed({2'b00, tgt});
    c    = $signed({2'b00, cur});
    m    = $signed({2'b00, cfg.midpoint});
    step = $signed({4'b0000, cfg.step_size});
    dmt  = (m - t < 0) ? t - m : m - t;
    dmc  = (m - c < 0) ? c - m : m - c;
    diff = t - c;
    mag  = (diff < 0) ? -diff : diff;
    if (mag > step) mag = step;
    if (diff < 0) begin
      res = c - mag;
      if (res > $signed({2'b00, cfg.deadzone_low})) res = $signed({2'b00, cfg.deadzone_low});
    end else if (diff > 0) begin
      res = c + mag;
      if (res < $signed({2'b00, cfg.deadzone_high})) res = $signed({2'b00, cfg.deadzone_high});
    end else begin
      res = c;
    end
    // stop at the midpoint when crossing it, jump when power drops
    if ((c < m && m < t) || (t < m && m < c)) begin
      return cfg.midpoint;
    end else if (dmt < dmc) begin
      return tgt;
    end else begin
      return res[PULSE_W-1:0];
    end
  endfunction

endpackage

// File: rtl/tms_front.sv
// ----------------------------------------------------------------------------
// tms_front: command decode and throttle/yaw mixing
// Accepts input beats, checks ranges, keeps the stored percents, and turns
// each beat into one decoded command for the back end. Two stages: a decode
// register holding the span product, then the mix into the command queue.
// ----------------------------------------------------------------------------
module tms_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tms_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic [tms_pkg::IN_TUSER_W-1:0] s_tuser,
  input  tms_pkg::cfg_t              cfg,
  output logic                       push,
  input  logic                       full,
  output tms_pkg::cmd_t              push_cmd
);
  import tms_pkg::*;

  function automatic logic pulse_ok(input logic [PULSE_W-1:0] v);
    return (v >= 12'd1000) && (v <= 12'd2000);
  endfunction

  function automatic logic pct_ok(input logic signed [7:0] v);
    return (v >= -8'sd100) && (v <= 8'sd100);
  endfunction

  // stored percents
  logic signed [7:0] throttle_pct, yaw_pct;
  logic signed [7:0] throttle_pct_next, yaw_pct_next;

  // decode stage registers
  logic              s1_valid;
  cmd_t              s1_cmd;
  logic              s1_mix;
  logic [16:0]       s1_prod;
  logic              s1_thr_neg;
  logic signed [8:0] s1_turn;

  // input field unpack
  logic [3:0]         op;
  logic [PULSE_W-1:0] pv, vv, sv;
  logic               byp;
  logic signed [7:0]  pct;
  logic               accept;

  cmd_t              dec_cmd;
  logic              dec_mix;
  logic [6:0]        thr_mag, yaw_mag;
  logic [SPAN_W-1:0] span;
  logic [16:0]       dec_prod;
  logic [9:0]        turn_x5;
  logic signed [8:0] dec_turn;
  logic signed [12:0] lift;

  assign op  = s_tuser[3:0];
  assign pv  = s_tdata[11:0];
  assign vv  = s_tdata[23:12];
  assign sv  = s_tdata[35:24];
  assign byp = s_tdata[36];
  assign pct = $signed(s_tdata[44:37]);

  assign s_tready = !s1_valid || !full;
  assign accept   = s_tvalid && s_tready;
  assign push     = s1_valid && !full;

  // decode one beat
  always_comb begin
    throttle_pct_next = throttle_pct;
    yaw_pct_next      = yaw_pct;
    if (op == OP_THROTTLE && pct_ok(pct)) throttle_pct_next = pct;
    if (op == OP_YAW && pct_ok(pct))      yaw_pct_next      = pct;

    thr_mag  = throttle_pct_next[7] ? 7'(-throttle_pct_next) : throttle_pct_next[6:0];
    yaw_mag  = yaw_pct_next[7] ? 7'(-yaw_pct_next) : yaw_pct_next[6:0];
    span     = throttle_pct_next[7] ? cfg.reverse_span : cfg.forward_span;
    dec_prod = {7'd0, span} * {10'd0, thr_mag};
    turn_x5  = {3'b000, yaw_mag} + {1'b0, yaw_mag, 2'b00};
    dec_turn = yaw_pct_next[7] ? -$signed({1'b0, turn_x5[8:1]}) : $signed({1'b0, turn_x5[8:1]});
    lift     = 13'sd1500 + $signed({{5{pct[7]}}, pct}) * 13'sd5;

    dec_cmd.kind      = CMD_NOP;
    dec_cmd.mask      = '0;
    dec_cmd.port      = pv;
    dec_cmd.vertical  = vv;
    dec_cmd.starboard = sv;
    dec_cmd.arm       = byp;
    dec_mix           = 1'b0;
    case (op)
      OP_SET_ALL: begin
        if (pulse_ok(pv) && pulse_ok(vv) && pulse_ok(sv)) begin
          dec_cmd.kind = CMD_SET;
          dec_cmd.mask = AXIS_PORT | AXIS_VERTICAL | AXIS_STARBOARD;
        end
      end
      OP_PORT: begin
        if (pulse_ok(pv)) begin
          dec_cmd.kind = CMD_SET;
          dec_cmd.mask = AXIS_PORT;
        end
      end
      OP_VERTICAL: begin
        if (pulse_ok(vv)) begin
          dec_cmd.kind = CMD_SET;
          dec_cmd.mask = AXIS_VERTICAL;
        end
      end
      OP_STARBOARD: begin
        if (pulse_ok(sv)) begin
          dec_cmd.kind = CMD_SET;
          dec_cmd.mask = AXIS_STARBOARD;
        end
      end
      OP_THROTTLE, OP_YAW: begin
        dec_cmd.kind = CMD_SET;
        dec_cmd.mask = AXIS_PORT | AXIS_STARBOARD;
        dec_cmd.arm  = 1'b0;
        dec_mix      = 1'b1;
      end
      OP_LIFT: begin
        if (pct_ok(pct)) begin
          dec_cmd.kind     = CMD_SET;
          dec_cmd.mask     = AXIS_VERTICAL;
          dec_cmd.vertical = lift[PULSE_W-1:0];
          dec_cmd.arm      = 1'b0;
        end
      end
      OP_STOP: dec_cmd.kind = CMD_STOP;
      OP_TICK: dec_cmd.kind = CMD_TICK;
      default: dec_cmd.kind = CMD_NOP;
    endcase
  end

  // percent registers and decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_pct <= '0;
      yaw_pct      <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        throttle_pct <= throttle_pct_next;
        yaw_pct      <= yaw_pct_next;
      end
      if (s_tready) s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= dec_cmd;
      s1_mix     <= dec_mix;
      s1_prod    <= dec_prod;
      s1_thr_neg <= throttle_pct_next[7];
      s1_turn    <= dec_turn;
    end
  end

  // mix: divide span product by 100 through a reciprocal, then offset clamp
  logic [29:0]        recip;
  logic [9:0]         q;
  logic signed [13:0] q_s, power, turn, aturn, off, mix_a, mix_b;

  always_comb begin
    recip = {13'd0, s1_prod} * 30'd5243;
    q     = recip[28:19];
    q_s   = $signed({4'b0000, q});
    power = 14'sd1500 + (s1_thr_neg ? -q_s : q_s);
    turn  = 14'(s1_turn);
    aturn = (turn < 0) ? -turn : turn;
    if (!s1_thr_neg) begin
      off = aturn + power - 14'sd2000;
      if (off < 0) off = '0;
      mix_a = power + turn - off;
      mix_b = power - turn - off;
    end else begin
      off = 14'sd1000 - (power - aturn);
      if (off < 0) off = '0;
      mix_a = power + turn + off;
      mix_b = power - turn + off;
    end
    push_cmd = s1_cmd;
    if (s1_mix) begin
      push_cmd.port      = mix_a[PULSE_W-1:0];
      push_cmd.starboard = mix_b[PULSE_W-1:0];
    end
  end

endmodule

// File: rtl/tms_queue.sv
// ----------------------------------------------------------------------------
// tms_queue: command queue between front end and back end
// Small register FIFO of decoded commands; lets either side stall alone.
// ----------------------------------------------------------------------------
module tms_queue #(
  parameter int unsigned Depth = tms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tms_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tms_pkg::cmd_t pop_cmd
);
  import tms_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  // store the beat
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/tms_back.sv
// ----------------------------------------------------------------------------
// tms_back: target store, slew limiter and result register
// Runs one queued command per cycle unless the output stalls: writes targets,
// stops, or steps the three drives. Every command yields one result beat.
// ----------------------------------------------------------------------------
module tms_back (
  input  logic                         clk,
  input  logic                         rst,
  input  tms_pkg::cfg_t                cfg,
  input  logic                         empty,
  input  tms_pkg::cmd_t                pop_cmd,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tms_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import tms_pkg::*;

  logic [PULSE_W-1:0] target_port, target_vertical, target_starboard;
  logic [PULSE_W-1:0] drive_port, drive_vertical, drive_starboard;
  logic               bypass_pending;

  logic [PULSE_W-1:0] target_port_next, target_vertical_next, target_starboard_next;
  logic [PULSE_W-1:0] drive_port_next, drive_vertical_next, drive_starboard_next;
  logic               bypass_pending_next;
  logic               moved_next;

  // result register
  logic [PULSE_W-1:0] res_port, res_vertical, res_starboard;
  logic               res_moved;

  assign pop = !empty && (!m_tvalid || m_tready);

  // execute one command
  always_comb begin
    target_port_next      = target_port;
    target_vertical_next  = target_vertical;
    target_starboard_next = target_starboard;
    drive_port_next       = drive_port;
    drive_vertical_next   = drive_vertical;
    drive_starboard_next  = drive_starboard;
    bypass_pending_next   = bypass_pending;
    moved_next            = 1'b0;
    case (pop_cmd.kind)
      CMD_SET: begin
        if ((pop_cmd.mask & AXIS_PORT) != '0)      target_port_next      = pop_cmd.port;
        if ((pop_cmd.mask & AXIS_VERTICAL) != '0)  target_vertical_next  = pop_cmd.vertical;
        if ((pop_cmd.mask & AXIS_STARBOARD) != '0) target_starboard_next = pop_cmd.starboard;
        if (pop_cmd.arm) bypass_pending_next = 1'b1;
      end
      CMD_STOP: begin
        target_port_next      = cfg.midpoint;
        target_vertical_next  = cfg.midpoint;
        target_starboard_next = cfg.midpoint;
      end
      CMD_TICK: begin
        if (target_port != drive_port || target_vertical != drive_vertical ||
            target_starboard != drive_starboard) begin
          moved_next = 1'b1;
          if (bypass_pending) begin
            drive_port_next      = target_port;
            drive_vertical_next  = target_vertical;
            drive_starboard_next = target_starboard;
            bypass_pending_next  = 1'b0;
          end else begin
            drive_port_next      = approach(target_port, drive_port, cfg);
            drive_vertical_next  = approach(target_vertical, drive_vertical, cfg);
            drive_starboard_next = approach(target_starboard, drive_starboard, cfg);
          end
        end
      end
      default: moved_next = 1'b0;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      target_port      <= NEUTRAL_PULSE;
      target_vertical  <= NEUTRAL_PULSE;
      target_starboard <= NEUTRAL_PULSE;
      drive_port       <= NEUTRAL_PULSE;
      drive_vertical   <= NEUTRAL_PULSE;
      drive_starboard  <= NEUTRAL_PULSE;
      bypass_pending   <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (pop) begin
        target_port      <= target_port_next;
        target_vertical  <= target_vertical_next;
        target_starboard <= target_starboard_next;
        drive_port       <= drive_port_next;
        drive_vertical   <= drive_vertical_next;
        drive_starboard  <= drive_starboard_next;
        bypass_pending   <= bypass_pending_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hold result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      res_port      <= drive_port_next;
      res_vertical  <= drive_vertical_next;
      res_starboard <= drive_starboard_next;
      res_moved     <= moved_next;
    end
  end

  // forward percent: trunc((avg - 1000) / 5) - 100, saturated to 8 bits
  logic [12:0]        sum;
  logic signed [12:0] dev;
  logic [11:0]        dev_mag;
  logic [23:0]        recip;
  logic signed [11:0] q_s, fwd;
  logic [7:0]         fwd_sat;

  always_comb begin
    sum     = {1'b0, res_port} + {1'b0, res_starboard};
    dev     = $signed({1'b0, sum[12:1]}) - 13'sd1000;
    dev_mag = (dev < 0) ? 12'(-dev) : dev[11:0];
    recip   = {12'd0, dev_mag} * 24'd3277;
    q_s     = $signed({2'b00, recip[23:14]});
    fwd     = ((dev < 0) ? -q_s : q_s) - 12'sd100;
    if (fwd > 12'sd127)       fwd_sat = 8'h7f;
    else if (fwd < -12'sd128) fwd_sat = 8'h80;
    else                      fwd_sat = fwd[7:0];
  end

  assign m_tdata = {3'b000, res_moved, fwd_sat, res_starboard, res_vertical, res_port};

endmodule

// File: rtl/thruster_mixer_slew_limiter.sv
// ----------------------------------------------------------------------------
// thruster_mixer_slew_limiter: thruster command mixer with slew limiting
// Front end decodes commands and mixes throttle/yaw into port and starboard
// targets; back end holds targets and drives and steps drives on each tick.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser: opcode; tdata: pulses, bypass, pct
//  m_*       out  m_tvalid/m_tready    tdata: three positions, fwd pct, moved
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One beat in, one beat out; a new beat is taken every cycle when the
//  output is drained. Beats pass the decode register, queue and
//  result register. Reset (rst, synchronous) loads register defaults and puts
//  all targets and drives at 1500. A stalled output fills the command queue
//  and then the decode register before s_tready drops. cfg_ready is always high.
//
module thruster_mixer_slew_limiter #(
  parameter int unsigned QueueDepth = tms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [11:0] port_value, [23:12] vertical_value, [35:24] starboard_value,
  // [36] bypass_request, [44:37] percent, [47:45] zero
  input  logic [tms_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [3:0] opcode
  input  logic [tms_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [11:0] port_pos, [23:12] vertical_pos, [35:24] starboard_pos,
  // [43:36] forward_percent, [44] moved, [47:45] zero
  output logic [tms_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tms_pkg::*;

  cfg_t cfg;
  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size     <= STEP_SIZE_RST;
      cfg.deadzone_low  <= DEADZONE_LOW_RST;
      cfg.deadzone_high <= DEADZONE_HIGH_RST;
      cfg.midpoint      <= MIDPOINT_RST;
      cfg.forward_span  <= SPAN_RST;
      cfg.reverse_span  <= SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_SIZE:     cfg.step_size     <= cfg_data[SPAN_W-1:0];
        REG_DEADZONE_LOW:  cfg.deadzone_low  <= cfg_data[PULSE_W-1:0];
        REG_DEADZONE_HIGH: cfg.deadzone_high <= cfg_data[PULSE_W-1:0];
        REG_MIDPOINT:      cfg.midpoint      <= cfg_data[PULSE_W-1:0];
        REG_FORWARD_SPAN:  cfg.forward_span  <= cfg_data[SPAN_W-1:0];
        REG_REVERSE_SPAN:  cfg.reverse_span  <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  tms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .push_cmd (push_cmd)
  );

  tms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_cmd  (pop_cmd)
  );

  tms_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: tb/sv/thruster_mixer_slew_limiter_test.sv
// ----------------------------------------------------------------------------
// thruster_mixer_slew_limiter_test: self-checking bench for the thruster mixer
// Drives pulse, mix, lift, stop and tick commands on the input stream and
// checks every output beat against a built-in predictor of targets, drives and
// slew. A short directed table comes first, then random phases under several
// register settings and idle patterns, two with a long output stall.
// ----------------------------------------------------------------------------
module thruster_mixer_slew_limiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tms_pkg::*;

  // Opcodes and register indexes the block does not decode
  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int PULSE_MIN        = 1000;
  localparam int PULSE_MAX        = 2000;
  localparam int PCT_LIMIT        = 100;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOLD_CYCLES      = 80;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [11:0]        port_value;
    logic [11:0]        vertical_value;
    logic [11:0]        starboard_value;
    logic               bypass;
    logic signed [7:0]  percent;
  } command_t;

  typedef struct packed {
    logic [11:0]        port_pos;
    logic [11:0]        vertical_pos;
    logic [11:0]        starboard_pos;
    logic signed [7:0]  forward_percent;
    logic               moved;
  } position_t;

  typedef struct {
    command_t  cmd;
    bit        fixed;
    position_t want;
  } directed_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  thruster_mixer_slew_limiter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: registers, targets, drives, stored percents
  cfg_t        cfg_shadow;
  logic [11:0] tgt_port, tgt_vert, tgt_stbd;
  logic [11:0] drv_port, drv_vert, drv_stbd;
  int          throttle, yaw;
  bit          bypass_armed;

  position_t     expected_positions[$];
  directed_row_t plan[$];
  int            bad_beats;
  int            tx_idle_pct;
  int            rx_idle_pct;
  bit            stall_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int magnitude(int x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic bit pulse_ok(logic [11:0] v);
    return v >= PULSE_MIN && v <= PULSE_MAX;
  endfunction

  function automatic bit pct_ok(int v);
    return v >= -PCT_LIMIT && v <= PCT_LIMIT;
  endfunction

  // One slew step of a drive toward its target
  function automatic logic [11:0] slew_toward(logic [11:0] goal, logic [11:0] now);
    int t, c, m, diff, mag, res;
    t = goal;
    c = now;
    m = cfg_shadow.midpoint;
    // stop at the midpoint when crossing it
    if ((c < m && m < t) || (t < m && m < c)) return cfg_shadow.midpoint;
    // power drops: go straight there
    if (magnitude(m - t) < magnitude(m - c)) return goal;
    diff = t - c;
    mag = magnitude(diff);
    if (mag > int'(cfg_shadow.step_size)) mag = cfg_shadow.step_size;
    if (diff < 0) begin
      res = c - mag;
      if (res > int'(cfg_shadow.deadzone_low)) res = cfg_shadow.deadzone_low;
    end else if (diff > 0) begin
      res = c + mag;
      if (res < int'(cfg_shadow.deadzone_high)) res = cfg_shadow.deadzone_high;
    end else begin
      res = c;
    end
    return res[11:0];
  endfunction

  // Mix stored throttle and yaw into port and starboard targets
  function automatic void remix();
    int span, power, turn, off, a, b;
    span = (throttle >= 0) ? int'(cfg_shadow.forward_span) : int'(cfg_shadow.reverse_span);
    power = int'(NEUTRAL_PULSE) + span * throttle / 100;
    turn = yaw * 250 / 100;
    if (throttle >= 0) begin
      off = magnitude(turn) + power - PULSE_MAX;
      if (off < 0) off = 0;
      a = power + turn - off;
      b = power - turn - off;
    end else begin
      off = PULSE_MIN - (power - magnitude(turn));
      if (off < 0) off = 0;
      a = power + turn + off;
      b = power - turn + off;
    end
    tgt_port = a[11:0];
    tgt_stbd = b[11:0];
  endfunction

  // Apply one accepted command and return the output beat it causes
  function automatic position_t thruster_step(command_t c);
    position_t r;
    int        pct, lifted, avg, fwd;
    bit        moved;
    pct = $signed(c.percent);
    moved = 1'b0;
    case (c.opcode)
      OP_SET_ALL: begin
        if (pulse_ok(c.port_value) && pulse_ok(c.vertical_value) &&
            pulse_ok(c.starboard_value)) begin
          tgt_port = c.port_value;
          tgt_vert = c.vertical_value;
          tgt_stbd = c.starboard_value;
          if (c.bypass) bypass_armed = 1'b1;
        end
      end
      OP_PORT: begin
        if (pulse_ok(c.port_value)) begin
          tgt_port = c.port_value;
          if (c.bypass) bypass_armed = 1'b1;
        end
      end
      OP_VERTICAL: begin
        if (pulse_ok(c.vertical_value)) begin
          tgt_vert = c.vertical_value;
          if (c.bypass) bypass_armed = 1'b1;
        end
      end
      OP_STARBOARD: begin
        if (pulse_ok(c.starboard_value)) begin
          tgt_stbd = c.starboard_value;
          if (c.bypass) bypass_armed = 1'b1;
        end
      end
      OP_THROTTLE: begin
        if (pct_ok(pct)) throttle = pct;
        remix();
      end
      OP_YAW: begin
        if (pct_ok(pct)) yaw = pct;
        remix();
      end
      OP_LIFT: begin
        if (pct_ok(pct)) begin
          lifted = int'(NEUTRAL_PULSE) + 5 * pct;
          tgt_vert = lifted[11:0];
        end
      end
      OP_STOP: begin
        tgt_port = cfg_shadow.midpoint;
        tgt_vert = cfg_shadow.midpoint;
        tgt_stbd = cfg_shadow.midpoint;
      end
      OP_TICK: begin
        if (tgt_port != drv_port || tgt_vert != drv_vert || tgt_stbd != drv_stbd) begin
          drv_port = slew_toward(tgt_port, drv_port);
          drv_vert = slew_toward(tgt_vert, drv_vert);
          drv_stbd = slew_toward(tgt_stbd, drv_stbd);
          // a pending bypass jumps straight to the targets
          if (bypass_armed) begin
            drv_port = tgt_port;
            drv_vert = tgt_vert;
            drv_stbd = tgt_stbd;
            bypass_armed = 1'b0;
          end
          moved = 1'b1;
        end
      end
      default: ;
    endcase
    avg = (int'(drv_port) + int'(drv_stbd)) / 2;
    fwd = (avg - PULSE_MIN) * 200 / 1000 - 100;
    if (fwd > 127) fwd = 127;
    if (fwd < -128) fwd = -128;
    r.port_pos = drv_port;
    r.vertical_pos = drv_vert;
    r.starboard_pos = drv_stbd;
    r.forward_percent = fwd[7:0];
    r.moved = moved;
    return r;
  endfunction

  function automatic directed_row_t row(logic [3:0] op, int p, int v, int s, bit byp,
                                        int pct);
    directed_row_t r;
    r.cmd.opcode = op;
    r.cmd.port_value = p[11:0];
    r.cmd.vertical_value = v[11:0];
    r.cmd.starboard_value = s[11:0];
    r.cmd.bypass = byp;
    r.cmd.percent = pct[7:0];
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // Attach an expectation that is plain from the command itself
  function automatic directed_row_t pinned(directed_row_t r, int pp, int vp, int sp, int fwd,
                                           bit mv);
    r.fixed = 1'b1;
    r.want.port_pos = pp[11:0];
    r.want.vertical_pos = vp[11:0];
    r.want.starboard_pos = sp[11:0];
    r.want.forward_percent = fwd[7:0];
    r.want.moved = mv;
    return r;
  endfunction

  function automatic logic [11:0] rand_pulse();
    logic [11:0] v;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      v = 12'($urandom_range(PULSE_MIN, PULSE_MAX));
    end else if (roll < 88) begin
      case ($urandom_range(0, 3))
        0:       v = 12'(PULSE_MIN - 1);
        1:       v = 12'(PULSE_MIN);
        2:       v = 12'(PULSE_MAX);
        default: v = 12'(PULSE_MAX + 1);
      endcase
    end else begin
      v = 12'($urandom);
    end
    return v;
  endfunction

  // Random payload around a chosen opcode
  function automatic command_t random_fields(logic [3:0] op);
    command_t c;
    int       roll, pct;
    c.opcode = op;
    c.port_value = rand_pulse();
    c.vertical_value = rand_pulse();
    c.starboard_value = rand_pulse();
    c.bypass = ($urandom_range(0, 5) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      pct = int'($urandom_range(0, 2 * PCT_LIMIT)) - PCT_LIMIT;
    end else if (roll < 90) begin
      case ($urandom_range(0, 3))
        0:       pct = -PCT_LIMIT - 1;
        1:       pct = -PCT_LIMIT;
        2:       pct = PCT_LIMIT;
        default: pct = PCT_LIMIT + 1;
      endcase
    end else begin
      pct = $urandom;
    end
    c.percent = pct[7:0];
    return c;
  endfunction

  // Offer one command beat, idle at random first, record its expectation
  task automatic send(command_t c, bit fixed, position_t want);
    position_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.opcode;
    s_tdata <= {3'b000, c.percent, c.bypass, c.starboard_value, c.vertical_value,
                c.port_value};
    do @(posedge clk); while (!s_tready);
    predicted = thruster_step(c);
    expected_positions.push_back(fixed ? want : predicted);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_positions.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STEP_SIZE:     cfg_shadow.step_size = val[SPAN_W-1:0];
      REG_DEADZONE_LOW:  cfg_shadow.deadzone_low = val;
      REG_DEADZONE_HIGH: cfg_shadow.deadzone_high = val;
      REG_MIDPOINT:      cfg_shadow.midpoint = val;
      REG_FORWARD_SPAN:  cfg_shadow.forward_span = val[SPAN_W-1:0];
      REG_REVERSE_SPAN:  cfg_shadow.reverse_span = val[SPAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(int step, int dz_lo, int dz_hi, int mid, int fwd_span,
                                int rev_span);
    write_reg(REG_STEP_SIZE, CFG_DATA_W'(step));
    write_reg(REG_DEADZONE_LOW, CFG_DATA_W'(dz_lo));
    write_reg(REG_DEADZONE_HIGH, CFG_DATA_W'(dz_hi));
    write_reg(REG_MIDPOINT, CFG_DATA_W'(mid));
    write_reg(REG_FORWARD_SPAN, CFG_DATA_W'(fwd_span));
    write_reg(REG_REVERSE_SPAN, CFG_DATA_W'(rev_span));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random back-pressure, or a long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold_left = HOLD_CYCLES;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare each output beat with the oldest expectation
  always @(posedge clk) begin
    position_t seen, want;
    if (!rst && m_tvalid && m_tready) begin
      seen.port_pos = m_tdata[11:0];
      seen.vertical_pos = m_tdata[23:12];
      seen.starboard_pos = m_tdata[35:24];
      seen.forward_percent = m_tdata[43:36];
      seen.moved = m_tdata[44];
      if (expected_positions.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS)
          $display("unexpected output beat: port %0d vert %0d stbd %0d fwd %0d moved %0d",
                   seen.port_pos, seen.vertical_pos, seen.starboard_pos,
                   seen.forward_percent, seen.moved);
      end else begin
        want = expected_positions.pop_front();
        if (seen.port_pos !== want.port_pos || seen.vertical_pos !== want.vertical_pos ||
            seen.starboard_pos !== want.starboard_pos ||
            seen.forward_percent !== want.forward_percent || seen.moved !== want.moved) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("mismatch: want %0d/%0d/%0d f%0d m%0d, got %0d/%0d/%0d f%0d m%0d",
                     want.port_pos, want.vertical_pos, want.starboard_pos,
                     want.forward_percent, want.moved, seen.port_pos, seen.vertical_pos,
                     seen.starboard_pos, seen.forward_percent, seen.moved);
        end
      end
    end
  end

  initial begin
    command_t   c;
    logic [3:0] op;
    int         counted, burst, roll;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    bad_beats = 0;
    stall_request = 1'b0;
    tx_idle_pct = 25;
    rx_idle_pct = 63;

    // Predictor starts from the reset state
    cfg_shadow.step_size = STEP_SIZE_RST;
    cfg_shadow.deadzone_low = DEADZONE_LOW_RST;
    cfg_shadow.deadzone_high = DEADZONE_HIGH_RST;
    cfg_shadow.midpoint = MIDPOINT_RST;
    cfg_shadow.forward_span = SPAN_RST;
    cfg_shadow.reverse_span = SPAN_RST;
    tgt_port = NEUTRAL_PULSE;
    tgt_vert = NEUTRAL_PULSE;
    tgt_stbd = NEUTRAL_PULSE;
    drv_port = NEUTRAL_PULSE;
    drv_vert = NEUTRAL_PULSE;
    drv_stbd = NEUTRAL_PULSE;
    throttle = 0;
    yaw = 0;
    bypass_armed = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset state, spare opcode, held bypass, invalid pulses, mix extremes
    plan.push_back(pinned(row(OP_TICK, 1500, 1500, 1500, 0, 0), 1500, 1500, 1500, 0, 0));
    plan.push_back(pinned(row(OP_SPARE_HI, 4095, 4095, 4095, 1, -1),
                          1500, 1500, 1500, 0, 0));
    plan.push_back(pinned(row(OP_PORT, 1500, 0, 0, 1, 0), 1500, 1500, 1500, 0, 0));
    plan.push_back(pinned(row(OP_TICK, 0, 0, 0, 0, 0), 1500, 1500, 1500, 0, 0));
    plan.push_back(pinned(row(OP_SET_ALL, 2000, 1000, 2000, 0, 0), 1500, 1500, 1500, 0, 0));
    plan.push_back(pinned(row(OP_TICK, 0, 0, 0, 0, 0), 2000, 1000, 2000, 100, 1));
    plan.push_back(pinned(row(OP_SET_ALL, 999, 1500, 1500, 1, 0), 2000, 1000, 2000, 100, 0));
    plan.push_back(pinned(row(OP_SET_ALL, 1500, 1500, 2001, 1, 0), 2000, 1000, 2000, 100, 0));
    plan.push_back(row(OP_PORT, 1000, 0, 0, 0, 0));
    plan.push_back(row(OP_TICK, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_TICK, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_VERTICAL, 0, 4095, 0, 1, 0));
    plan.push_back(row(OP_STARBOARD, 0, 0, 0, 1, 0));
    plan.push_back(row(OP_THROTTLE, 0, 0, 0, 0, 100));
    plan.push_back(row(OP_YAW, 0, 0, 0, 0, 100));
    plan.push_back(row(OP_TICK, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_YAW, 0, 0, 0, 0, -100));
    plan.push_back(row(OP_THROTTLE, 0, 0, 0, 0, -100));
    plan.push_back(row(OP_THROTTLE, 0, 0, 0, 0, 127));
    plan.push_back(row(OP_YAW, 0, 0, 0, 0, -128));
    plan.push_back(row(OP_LIFT, 0, 0, 0, 0, 100));
    plan.push_back(row(OP_LIFT, 0, 0, 0, 0, -100));
    plan.push_back(row(OP_LIFT, 0, 0, 0, 0, 101));
    plan.push_back(row(OP_TICK, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_STOP, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_TICK, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_SPARE_LO, 1000, 2000, 1000, 0, 50));
    foreach (plan[i]) send(plan[i].cmd, plan[i].fixed, plan[i].want);
    drop_valid();
    drain();

    // Random phases: new settings each, idle pattern rotates
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       begin tx_idle_pct = 25; rx_idle_pct = 63; end
        1:       begin tx_idle_pct = 63; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      case (p)
        0: begin
          write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
          write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
          write_settings(40, 1450, 1550, 1500, 500, 500);
        end
        1: write_settings(1, 1500, 1500, 1500, 0, 0);
        2: write_settings(1000, 0, 4095, 0, 1000, 1000);
        3: begin
          write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
          write_settings($urandom_range(1, 1000), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(1000, 2000),
                         $urandom_range(0, 1000), $urandom_range(0, 1000));
        end
        4: write_settings(7, 1400, 1600, 4095, 250, 750);
        default: write_settings(64, 1450, 1550, 1500, 500, 500);
      endcase
      // hold the output while the input keeps offering beats
      if (p % 3 == 2) stall_request = 1'b1;

      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          burst = $urandom_range(4, 16);
          repeat (burst) send(random_fields(OP_TICK), 1'b0, '0);
          counted += burst;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 30)      op = OP_TICK;
          else if (roll < 40) op = OP_SET_ALL;
          else if (roll < 47) op = OP_PORT;
          else if (roll < 54) op = OP_VERTICAL;
          else if (roll < 61) op = OP_STARBOARD;
          else if (roll < 70) op = OP_THROTTLE;
          else if (roll < 79) op = OP_YAW;
          else if (roll < 86) op = OP_LIFT;
          else if (roll < 93) op = OP_STOP;
          else                op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
          c = random_fields(op);
          send(c, 1'b0, '0);
          counted++;
        end
      end
      drop_valid();
      drain();
    end

    repeat (8) @(posedge clk);
    if (bad_beats == 0 && expected_positions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
